[design/bsr_pkg.sv]
// Shared types, constants and header checks for the BMP stream to RGBA decoder.
`default_nettype none

package bsr_pkg;

   // Image size limits accepted by the decoder.
   localparam int unsigned MAX_WIDTH  = 4096;
   localparam int unsigned MAX_HEIGHT = 4096;

   // Header layout and format constants.
   localparam logic [31:0] HDR_LEN   = 32'd34;
   localparam logic [31:0] LAST_HDR  = HDR_LEN - 32'd1;
   localparam logic [15:0] BMP_SIG   = 16'h4D42;
   localparam logic [31:0] MIN_INFO  = 32'd40;
   localparam logic [15:0] BPP_24    = 16'd24;
   localparam logic [15:0] BPP_32    = 16'd32;
   localparam logic [7:0]  COMP_RGB  = 8'd0;
   localparam logic [7:0]  COMP_BITF = 8'd3;
   localparam logic [7:0]  ALPHA_OPQ = 8'd255;

   // Column and row counters hold values up to the image limits.
   localparam int unsigned CNT_W = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1;

   // Request kinds carried in tuser.
   typedef enum logic {
      REQ_BYTE = 1'b0,
      REQ_EOF  = 1'b1
   } req_kind_type;

   // Result kinds carried in tuser.
   typedef enum logic {
      RSP_PIXEL  = 1'b0,
      RSP_STATUS = 1'b1
   } rsp_kind_type;

   // File status codes.
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_SIG     = 3'd1,
      ST_UNSUPPORTED = 3'd2,
      ST_TRUNCATED   = 3'd3,
      ST_INFO_SMALL  = 3'd4
   } status_type;

   // Header fields gathered from the first bytes of the file.
   typedef struct packed {
      logic [31:0] pixel_offset;
      logic [31:0] info_size;
      logic [31:0] width;
      logic [31:0] height;
      logic [15:0] signature;
      logic [15:0] planes;
      logic [15:0] bpp;
      logic [7:0]  compression;
      logic        comp_high;
   } hdr_type;

   // Magnitude of the signed image height.
   function automatic logic [31:0] height_mag(input logic [31:0] height);
      return height[31] ? (32'd0 - height) : height;
   endfunction

   // Signature and format checks on a header, bad signature ranked first.
   function automatic status_type header_status(input hdr_type h);
      logic [31:0] hmag;
      logic        bad;
      hmag = height_mag(h.height);
      bad  = (h.planes != 16'd1) || h.width[31] || (h.width == 32'd0) ||
             (h.width > 32'(MAX_WIDTH)) || (h.height == 32'd0) ||
             (hmag > 32'(MAX_HEIGHT)) ||
             ((h.bpp != BPP_24) && (h.bpp != BPP_32)) || h.comp_high ||
             ((h.compression != COMP_RGB) && (h.compression != COMP_BITF)) ||
             (h.pixel_offset < HDR_LEN);
      if (h.signature != BMP_SIG) begin
         return ST_BAD_SIG;
      end
      if (bad) begin
         return ST_UNSUPPORTED;
      end
      return ST_OK;
   endfunction

endpackage

`default_nettype wire

[design/bmp_stream_to_rgba_core.sv]
// Top level of the BMP byte stream to RGBA pixel decoder.
// A result is registered and presented on the rsp channel in the cycle after its transaction is accepted.
// Throughput: one file byte or end-of-file transaction per cycle while the rsp side is not stalled; the
// parse counters and compares on the header fields all settle within that cycle.
// Reset (synchronous, active high) clears the parser and drops any pending result.
// Every end-of-file transaction also returns the parser to its reset state.
`default_nettype none

module bmp_stream_to_rgba_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                         // [31:24] alpha, [43:32] column,
                                         // [55:44] target_row, [58:56] status, rest zero
   output logic             rsp_tuser    // [0] result_kind
);

   localparam int unsigned CW = bsr_pkg::CNT_W;

   // Parser state.
   logic [31:0]           byte_pos_ff, byte_pos_in;
   bsr_pkg::hdr_type      hdr_ff, hdr_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [CW-1:0]         src_row_ff, src_row_in;
   logic [1:0]            bip_ff, bip_in;
   logic [1:0]            pad_ff, pad_in;
   logic [23:0]           held_ff, held_in;
   bsr_pkg::status_type   file_status_ff, file_status_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [63:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   // Working signals.
   logic                  req_fire;
   logic                  is_eof;
   logic                  in_header;
   logic [31:0]           hmag;
   logic                  rows_left;
   logic                  four_bpp;
   logic [1:0]            lane;
   logic                  pix_active;
   logic                  emit;
   logic [CW-1:0]         col_next;
   logic [1:0]            row_pad;
   logic [7:0]            px_red, px_green, px_blue, px_alpha;
   logic [11:0]           px_row;
   bsr_pkg::status_type   eof_status;
   bsr_pkg::status_type   hdr_check;

   // A new transaction is taken whenever the result register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_eof     = (req_tuser == bsr_pkg::REQ_EOF);

   // Decoded header quantities used by the pixel path.
   assign in_header = (byte_pos_ff < bsr_pkg::HDR_LEN);
   assign hmag      = bsr_pkg::height_mag(hdr_ff.height);
   assign rows_left = ({{(32-CW){1'b0}}, src_row_ff} < hmag);
   assign four_bpp  = (hdr_ff.bpp == bsr_pkg::BPP_32);
   assign lane      = byte_pos_ff[1:0] + 2'd2;
   assign row_pad   = four_bpp ? 2'd0 : hdr_ff.width[1:0];
   assign col_next  = col_ff + CW'(1);

   // Merge the incoming byte into the header fields.
   always_comb begin
      hdr_in = hdr_ff;
      if (in_header) begin
         case (byte_pos_ff[5:0])
            6'd0, 6'd1: begin
               hdr_in.signature[{byte_pos_ff[0], 3'b000} +: 8] = req_tdata;
            end
            6'd10, 6'd11, 6'd12, 6'd13: begin
               hdr_in.pixel_offset[{lane, 3'b000} +: 8] = req_tdata;
            end
            6'd14, 6'd15, 6'd16, 6'd17: begin
               hdr_in.info_size[{lane, 3'b000} +: 8] = req_tdata;
            end
            6'd18, 6'd19, 6'd20, 6'd21: begin
               hdr_in.width[{lane, 3'b000} +: 8] = req_tdata;
            end
            6'd22, 6'd23, 6'd24, 6'd25: begin
               hdr_in.height[{lane, 3'b000} +: 8] = req_tdata;
            end
            6'd26, 6'd27: begin
               hdr_in.planes[{byte_pos_ff[0], 3'b000} +: 8] = req_tdata;
            end
            6'd28, 6'd29: begin
               hdr_in.bpp[{byte_pos_ff[0], 3'b000} +: 8] = req_tdata;
            end
            6'd30: begin
               hdr_in.compression = req_tdata;
            end
            6'd31, 6'd32, 6'd33: begin
               hdr_in.comp_high = hdr_ff.comp_high || (req_tdata != 8'd0);
            end
            default: begin
               hdr_in = hdr_ff;
            end
         endcase
      end
   end

   // Status checks: on the completed header, and at end of file.
   assign hdr_check = bsr_pkg::header_status(hdr_in);

   always_comb begin
      eof_status = bsr_pkg::header_status(hdr_ff);
      if (eof_status == bsr_pkg::ST_OK) begin
         if (rows_left) begin
            eof_status = bsr_pkg::ST_TRUNCATED;
         end else if (hdr_ff.info_size < bsr_pkg::MIN_INFO) begin
            eof_status = bsr_pkg::ST_INFO_SMALL;
         end
      end
   end

   // Pixel byte path: pixels are read once the header passed and the offset is reached.
   assign pix_active = !in_header && (file_status_ff == bsr_pkg::ST_OK) &&
                       (byte_pos_ff >= hdr_ff.pixel_offset) && rows_left;

   assign px_red   = four_bpp ? held_ff[23:16] : req_tdata;
   assign px_green = held_ff[15:8];
   assign px_blue  = held_ff[7:0];
   assign px_alpha = four_bpp ? req_tdata : bsr_pkg::ALPHA_OPQ;
   assign px_row   = hdr_ff.height[31] ? (hmag[11:0] - 12'd1 - src_row_ff[11:0])
                                       : src_row_ff[11:0];

   // Next state of the parser for the accepted transaction.
   always_comb begin
      byte_pos_in    = byte_pos_ff;
      col_in         = col_ff;
      src_row_in     = src_row_ff;
      bip_in         = bip_ff;
      pad_in         = pad_ff;
      held_in        = held_ff;
      file_status_in = file_status_ff;
      emit           = 1'b0;
      rsp_user_in    = bsr_pkg::RSP_PIXEL;
      rsp_data_in    = '0;
      if (is_eof) begin
         // End of file: report the status and go back to the reset state.
         byte_pos_in    = '0;
         col_in         = '0;
         src_row_in     = '0;
         bip_in         = '0;
         pad_in         = '0;
         held_in        = '0;
         file_status_in = bsr_pkg::ST_OK;
         emit           = 1'b1;
         rsp_user_in    = bsr_pkg::RSP_STATUS;
         rsp_data_in[58:56] = eof_status;
      end else begin
         if (byte_pos_ff != 32'hFFFF_FFFF) begin
            byte_pos_in = byte_pos_ff + 32'd1;
         end
         if (in_header) begin
            // Judge the header once its last byte is in.
            if (byte_pos_ff == bsr_pkg::LAST_HDR) begin
               file_status_in = hdr_check;
               if ((hdr_check == bsr_pkg::ST_OK) && (hdr_in.info_size < bsr_pkg::MIN_INFO)) begin
                  file_status_in = bsr_pkg::ST_INFO_SMALL;
               end
            end
         end else if (pix_active) begin
            if (pad_ff != 2'd0) begin
               // Drop a row padding byte.
               pad_in = pad_ff - 2'd1;
               if (pad_ff == 2'd1) begin
                  src_row_in = src_row_ff + CW'(1);
               end
            end else if (four_bpp ? (bip_ff != 2'd3) : (bip_ff != 2'd2)) begin
               // Hold a byte of the pixel being built.
               held_in[{bip_ff, 3'b000} +: 8] = req_tdata;
               bip_in = bip_ff + 2'd1;
            end else begin
               // Last byte of a pixel: emit it and advance the column.
               emit        = 1'b1;
               rsp_data_in = {5'd0, bsr_pkg::ST_OK, px_row, col_ff[11:0],
                              px_alpha, px_blue, px_green, px_red};
               held_in     = '0;
               bip_in      = '0;
               col_in      = col_next;
               if ({{(32-CW){1'b0}}, col_next} >= hdr_ff.width) begin
                  col_in = '0;
                  if (row_pad == 2'd0) begin
                     src_row_in = src_row_ff + CW'(1);
                  end else begin
                     pad_in = row_pad;
                  end
               end
            end
         end
      end
   end

   // Result register handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Parser and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff    <= '0;
         hdr_ff         <= '0;
         col_ff         <= '0;
         src_row_ff     <= '0;
         bip_ff         <= '0;
         pad_ff         <= '0;
         held_ff        <= '0;
         file_status_ff <= bsr_pkg::ST_OK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            byte_pos_ff    <= byte_pos_in;
            hdr_ff         <= is_eof ? '0 : hdr_in;
            col_ff         <= col_in;
            src_row_ff     <= src_row_in;
            bip_ff         <= bip_in;
            pad_ff         <= pad_in;
            held_ff        <= held_in;
            file_status_ff <= file_status_in;
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef ASSERT_OFF
   // An end-of-file transaction always yields a status result in the next cycle.
   a_eof_status: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_eof) |=> (rsp_tvalid && (rsp_tuser == bsr_pkg::RSP_STATUS)))
      else $error("end of file did not yield a status result");

   // End of file rewinds the byte position.
   a_eof_rewind: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_eof) |=> (byte_pos_ff == 32'd0))
      else $error("byte position not cleared after end of file");

   // Padding is only dropped between whole pixels.
   a_pad_aligned: assert property (@(posedge clock) disable iff (reset)
      (pad_ff != 2'd0) |-> (bip_ff == 2'd0))
      else $error("row padding while a pixel is partly built");

   // Pixels are only emitted after a header that passed.
   a_pixel_ok: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit && !is_eof) |-> (file_status_ff == bsr_pkg::ST_OK))
      else $error("pixel emitted for a rejected file");
`endif

endmodule

`default_nettype wire

[bench/bmp_rgba_checker.sv]
// Checker that predicts the decoder's pixel and status transactions and compares them.
module bmp_rgba_checker
   import bsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] req_type
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                         // [31:24] alpha, [43:32] column,
                                         // [55:44] target_row, [58:56] status
   input  wire logic        rsp_tuser,   // [0] result_kind
   output int               fail_count,
   output int               pending,
   output int               pixel_count,
   output int               file_count
);

   // One decoded result as the decoder should present it.
   typedef struct {
      rsp_kind_type kind;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      logic [7:0]   alpha;
      logic [11:0]  column;
      logic [11:0]  row;
      status_type   status;
   } rgba_result_t;

   rgba_result_t expected_q[$];

   // Parser state of the file being decoded.
   logic [31:0] byte_pos;
   logic [31:0] pix_offset;
   logic [31:0] info_size;
   logic [31:0] img_width;
   logic [31:0] img_height;
   logic [15:0] signature;
   logic [15:0] planes;
   logic [15:0] bpp;
   logic [7:0]  comp_low;
   logic        comp_high;
   logic [31:0] column_cnt;
   logic [31:0] row_cnt;
   int unsigned byte_idx;
   int unsigned pad_left;
   logic [23:0] held;
   status_type  file_status;

   // Number of stored rows, whatever the sign of the height.
   function automatic logic [31:0] rows_in_image();
      return img_height[31] ? (32'd0 - img_height) : img_height;
   endfunction

   // Signature first, then every format limit the decoder supports.
   function automatic status_type check_header();
      if (signature != BMP_SIG) begin
         return ST_BAD_SIG;
      end
      if (planes != 16'd1 || img_width[31] || img_width == 32'd0 ||
          img_width > MAX_WIDTH || img_height == 32'd0 || rows_in_image() > MAX_HEIGHT ||
          (bpp != BPP_24 && bpp != BPP_32) || comp_high ||
          (comp_low != COMP_RGB && comp_low != COMP_BITF) || pix_offset < HDR_LEN) begin
         return ST_UNSUPPORTED;
      end
      return ST_OK;
   endfunction

   task automatic clear_decoder();
      byte_pos    = '0;
      pix_offset  = '0;
      info_size   = '0;
      img_width   = '0;
      img_height  = '0;
      signature   = '0;
      planes      = '0;
      bpp         = '0;
      comp_low    = '0;
      comp_high   = 1'b0;
      column_cnt  = '0;
      row_cnt     = '0;
      byte_idx    = 0;
      pad_left    = 0;
      held        = '0;
      file_status = ST_OK;
   endtask

   // Header fields are little endian; the upper compression bytes only matter if nonzero.
   task automatic take_header_byte(input logic [31:0] pos, input logic [7:0] b);
      if (pos < 32'd2) begin
         signature[8*pos +: 8] = b;
      end else if (pos >= 32'd10 && pos < 32'd14) begin
         pix_offset[8*(pos-10) +: 8] = b;
      end else if (pos >= 32'd14 && pos < 32'd18) begin
         info_size[8*(pos-14) +: 8] = b;
      end else if (pos >= 32'd18 && pos < 32'd22) begin
         img_width[8*(pos-18) +: 8] = b;
      end else if (pos >= 32'd22 && pos < 32'd26) begin
         img_height[8*(pos-22) +: 8] = b;
      end else if (pos >= 32'd26 && pos < 32'd28) begin
         planes[8*(pos-26) +: 8] = b;
      end else if (pos >= 32'd28 && pos < 32'd30) begin
         bpp[8*(pos-28) +: 8] = b;
      end else if (pos == 32'd30) begin
         comp_low = b;
      end else if (pos > 32'd30 && b != 8'd0) begin
         comp_high = 1'b1;
      end
   endtask

   // Pixel data: padding bytes are dropped, and a full pixel yields one result.
   task automatic take_pixel_byte(input logic [7:0] b);
      int unsigned  per_pixel;
      int unsigned  pad;
      logic [31:0]  out_row;
      rgba_result_t r;
      per_pixel = (bpp == BPP_32) ? 4 : 3;
      if (pad_left != 0) begin
         pad_left--;
         if (pad_left == 0) begin
            row_cnt++;
         end
         return;
      end
      if (byte_idx + 1 < per_pixel) begin
         held[8*byte_idx +: 8] = b;
         byte_idx++;
         return;
      end
      // Top-down files count their rows from the top of the image.
      out_row = img_height[31] ? (rows_in_image() - 32'd1 - row_cnt) : row_cnt;
      r.kind  = RSP_PIXEL;
      r.blue  = held[7:0];
      r.green = held[15:8];
      if (per_pixel == 4) begin
         r.red   = held[23:16];
         r.alpha = b;
      end else begin
         r.red   = b;
         r.alpha = ALPHA_OPQ;
      end
      r.column = column_cnt[11:0];
      r.row    = out_row[11:0];
      r.status = ST_OK;
      expected_q.push_back(r);
      held     = '0;
      byte_idx = 0;
      column_cnt++;
      if (column_cnt >= img_width) begin
         pad = (4 - ((img_width * per_pixel) & 3)) & 3;
         column_cnt = '0;
         if (pad == 0) begin
            row_cnt++;
         end else begin
            pad_left = pad;
         end
      end
   endtask

   // Works out what one accepted input transaction causes.
   task automatic take_transaction(input logic kind, input logic [7:0] b);
      rgba_result_t r;
      status_type   st;
      if (kind == REQ_EOF) begin
         // Truncation outranks a small info header.
         st = check_header();
         if (st == ST_OK) begin
            if (row_cnt < rows_in_image()) begin
               st = ST_TRUNCATED;
            end else if (info_size < MIN_INFO) begin
               st = ST_INFO_SMALL;
            end
         end
         r.kind   = RSP_STATUS;
         r.red    = '0;
         r.green  = '0;
         r.blue   = '0;
         r.alpha  = '0;
         r.column = '0;
         r.row    = '0;
         r.status = st;
         expected_q.push_back(r);
         file_count++;
         clear_decoder();
         return;
      end
      if (byte_pos < HDR_LEN) begin
         take_header_byte(byte_pos, b);
         if (byte_pos == LAST_HDR) begin
            file_status = check_header();
            if (file_status == ST_OK && info_size < MIN_INFO) begin
               file_status = ST_INFO_SMALL;
            end
         end
      end else if (file_status == ST_OK && byte_pos >= pix_offset &&
                   row_cnt < rows_in_image()) begin
         take_pixel_byte(b);
      end
      if (byte_pos != 32'hFFFF_FFFF) begin
         byte_pos++;
      end
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         fail_count++;
      end
   endtask

   // Compares one accepted result transaction with the oldest expectation.
   task automatic compare_result();
      rgba_result_t want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual tuser %b tdata %h",
                  $time, rsp_tuser, rsp_tdata);
         fail_count++;
         return;
      end
      want = expected_q.pop_front();
      if (want.kind == RSP_PIXEL) begin
         pixel_count++;
      end
      check_field("result_kind", want.kind, rsp_tuser);
      check_field("red", want.red, rsp_tdata[7:0]);
      check_field("green", want.green, rsp_tdata[15:8]);
      check_field("blue", want.blue, rsp_tdata[23:16]);
      check_field("alpha", want.alpha, rsp_tdata[31:24]);
      check_field("column", want.column, rsp_tdata[43:32]);
      check_field("target_row", want.row, rsp_tdata[55:44]);
      check_field("status", want.status, rsp_tdata[58:56]);
      check_field("spare bits", 32'd0, rsp_tdata[63:59]);
   endtask

   // Requests are handled before results so a same-edge result finds its expectation.
   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         expected_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            take_transaction(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            compare_result();
         end
      end
      pending = expected_q.size();
   end

endmodule

[bench/bmp_stream_to_rgba_core_test.sv]
// Testbench top for the BMP stream to RGBA decoder: stimulus, flow control and verdict.
module bmp_stream_to_rgba_core_test;
   import bsr_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned DRAIN_LIMIT  = 20_000;
   localparam int unsigned RANDOM_BYTES = 200;
   localparam int          NO_CUT       = -1;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [63:0] rsp_tdata;
   wire         rsp_tuser;

   int          fail_count;
   int          pending;
   int          pixel_count;
   int          file_count;
   int          burst_left = 0;
   int          stall_asks = 0;
   int          bytes_sent = 0;
   int unsigned cycles     = 0;

   bmp_stream_to_rgba_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   bmp_rgba_checker rgba_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .pending     (pending),
      .pixel_count (pixel_count),
      .file_count  (file_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard limit on the length of the run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d results outstanding", $time, pending);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: changing stall patterns, plus a long hold-off whenever one is asked for.
   initial begin : result_sink
      int mode;
      int mode_left;
      int hold;
      int seen;
      mode      = 0;
      mode_left = 0;
      hold      = 0;
      seen      = 0;
      forever begin
         @(negedge clock);
         if (stall_asks != seen) begin
            seen = stall_asks;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offers one transaction in bursts with random gaps, returning after it is accepted.
   task automatic send_item(input req_kind_type kind, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 8);
         burst_left = $urandom_range(1, 60);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (kind == REQ_BYTE) begin
         bytes_sent++;
      end
   endtask

   // Sends a whole file: header, filler toward the pixel offset (at most 64 bytes), pixel rows, trailing
   // bytes, then the end-of-file transaction. A cut at or above zero but below the file length ends the file early.
   task automatic send_file(input logic [15:0] sig, input logic [31:0] offset,
                            input logic [31:0] info, input logic [31:0] width,
                            input logic [31:0] height, input logic [15:0] planes,
                            input logic [15:0] depth, input logic [31:0] comp,
                            input int cut, input int unsigned trail);
      logic [7:0]  head [34];
      logic [31:0] rows;
      int unsigned stride;
      int unsigned filler;
      int unsigned body;
      int unsigned total;
      int unsigned count;
      head[0] = sig[7:0];
      head[1] = sig[15:8];
      for (int i = 2; i < 10; i++) begin
         head[i] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < 4; i++) begin
         head[10+i] = offset[8*i +: 8];
         head[14+i] = info[8*i +: 8];
         head[18+i] = width[8*i +: 8];
         head[22+i] = height[8*i +: 8];
         head[30+i] = comp[8*i +: 8];
      end
      for (int i = 0; i < 2; i++) begin
         head[26+i] = planes[8*i +: 8];
         head[28+i] = depth[8*i +: 8];
      end
      // Size the pixel data for a plausible header, otherwise eight random bytes.
      rows = height[31] ? (32'd0 - height) : height;
      body = 8;
      if (width >= 1 && width <= MAX_WIDTH && rows >= 1 && rows <= MAX_HEIGHT) begin
         stride = (width * ((depth == BPP_32) ? 4 : 3) + 3) & ~32'd3;
         if (rows * stride <= 20000) begin
            body = rows * stride;
         end
      end
      filler = 0;
      if (offset > HDR_LEN) begin
         filler = (offset - HDR_LEN > 64) ? 64 : offset - HDR_LEN;
      end
      total = HDR_LEN + filler + body + trail;
      count = (cut >= 0 && cut < total) ? cut : total;
      for (int unsigned i = 0; i < count; i++) begin
         send_item(REQ_BYTE, (i < HDR_LEN) ? head[i] : 8'($urandom_range(0, 255)));
      end
      send_item(REQ_EOF, 8'($urandom_range(0, 255)));
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      int          start;
      int          wait_cycles;
      logic [15:0] sig;
      logic [15:0] planes;
      logic [15:0] depth;
      logic [31:0] offset;
      logic [31:0] info;
      logic [31:0] width;
      logic [31:0] height;
      logic [31:0] comp;
      int          cut;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty file, then small good files in both depths, orientations and paddings.
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0, 0, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0, NO_CUT, 5);
      send_file(BMP_SIG, 32'd54, 32'd40, 32'd3, -32'd2, 16'd1, BPP_32, 32'd3, NO_CUT, 0);
      send_file(BMP_SIG, 32'd40, 32'd124, 32'd2, 32'd3, 16'd1, BPP_24, 32'd0, NO_CUT, 2);
      // Bad signature and each unsupported header field.
      send_file(16'h4D43, 32'd34, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, 32'd1, 16'd2, BPP_24, 32'd0, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd0, 32'd1, 16'd1, BPP_24, 32'd0, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, -32'd3, 32'd1, 16'd1, BPP_24, 32'd0, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd4097, 32'd1, 16'd1, BPP_24, 32'd0, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, 32'd0, 16'd1, BPP_24, 32'd0, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, 32'd4097, 16'd1, BPP_24, 32'd0, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, -32'd4097, 16'd1, BPP_24, 32'd0, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, 32'd1, 16'd1, 16'd16, 32'd0, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd1, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'h100, NO_CUT, 0);
      send_file(BMP_SIG, 32'd33, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0, NO_CUT, 0);
      // Small info header, end inside the header, short pixel data, unreachable offset.
      send_file(BMP_SIG, 32'd34, 32'd12, 32'd2, 32'd2, 16'd1, BPP_24, 32'd0, NO_CUT, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0, 31, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0, 20, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd3, 32'd2, 16'd1, BPP_24, 32'd0, 44, 0);
      send_file(BMP_SIG, 32'hFFFF_FFFF, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0, NO_CUT, 0);
      // Start of the widest row while the result side holds off, then the tallest
      // top-down image; both end early.
      stall_asks++;
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd4096, 32'd1, 16'd1, BPP_24, 32'd0, 94, 0);
      send_file(BMP_SIG, 32'd34, 32'd40, 32'd1, -32'd4096, 16'd1, BPP_32, 32'd3, 42, 0);

      // Random files: mostly well formed with random content, some with a broken field.
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         sig    = BMP_SIG;
         planes = 16'd1;
         width  = $urandom_range(1, 7);
         height = $urandom_range(1, 5);
         if ($urandom_range(0, 1) == 1) begin
            height = 32'd0 - height;
         end
         depth  = ($urandom_range(0, 1) == 1) ? BPP_32 : BPP_24;
         comp   = ($urandom_range(0, 1) == 1) ? 32'(COMP_BITF) : 32'(COMP_RGB);
         offset = HDR_LEN + $urandom_range(0, 12);
         case ($urandom_range(0, 2))
            0: info = MIN_INFO;
            1: info = 32'd108;
            default: info = 32'd124;
         endcase
         cut = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 120)) : NO_CUT;
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 7))
               0: sig = 16'($urandom);
               1: planes = 16'($urandom);
               2: width = $urandom;
               3: height = $urandom;
               4: depth = 16'($urandom);
               5: comp = $urandom;
               6: offset = $urandom_range(0, 33);
               default: info = $urandom_range(0, 39);
            endcase
         end
         send_file(sig, offset, info, width, height, planes, depth, comp, cut,
                   $urandom_range(0, 3));
      end
      req_tvalid <= 1'b0;

      // Drain whatever is still expected, then watch for stray results.
      for (wait_cycles = 0; pending != 0 && wait_cycles < DRAIN_LIMIT; wait_cycles++) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
      if (pending != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending);
      end
      $display("Decoded %0d files from %0d file bytes; %0d pixel transactions checked.",
               file_count, bytes_sent, pixel_count);
      $display("Run covered header errors, early ends, padding, top-down rows, back-pressure.");
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
design/bsr_pkg.sv
design/bmp_stream_to_rgba_core.sv
bench/bmp_rgba_checker.sv
bench/bmp_stream_to_rgba_core_test.sv
